[src/keyframe_linear_interpolator_unit_assert.svh]
// assertion macros shared by the keyframe interpolator rtl
// expects signals clk and rst_n in the including module
`ifndef KEYFRAME_LINEAR_INTERPOLATOR_UNIT_ASSERT_SVH
`define KEYFRAME_LINEAR_INTERPOLATOR_UNIT_ASSERT_SVH

// same-cycle implication
`define KLI_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define KLI_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/klerp_pkg.sv]
// types and constants of the keyframe linear interpolator
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package klerp_pkg;

  typedef logic [2:0] op_t;

  localparam op_t OP_NONE     = 3'd0;
  localparam op_t OP_LOAD_DIV = 3'd1;
  localparam op_t OP_DIV_STEP = 3'd2;
  localparam op_t OP_LOAD_MUL = 3'd3;
  localparam op_t OP_MUL_STEP = 3'd4;
  localparam op_t OP_FINAL    = 3'd5;

  typedef struct packed {
    op_t  op;
    logic neg;
  } cmd_t;

  typedef logic [1:0] status_t;

  localparam status_t ST_INTERP = 2'd0;
  localparam status_t ST_SINGLE = 2'd1;
  localparam status_t ST_CLAMP  = 2'd2;

  localparam int unsigned VEC_W = 96;

endpackage

`default_nettype wire

[src/keyframe_linear_interpolator_unit.sv]
// Keyframe table with linear interpolation of a three-component 16.16 vector at a
// query time. A query item keeps the input not ready until done. It returns the
// first key with one key in use or for a time before that key, the last key when
// clamped past it, and a blend of keys i and i+1 for a time between them. A query
// also stalls while the output register still holds an unaccepted result. The
// length of a query is set by the time memory read port (one key compared per
// cycle in the linear search) and the one shared 34-bit add/subtract unit, which
// forms the blend factor by a 32-step restoring division and each component by a
// 32-step shift-add multiply plus a final add. A finished result waits in the
// output register while the next item is taken. Unwritten slots read back as
// undefined.
// depends on klerp_pkg, klerp_ram, klerp_arith and the assertion header
`timescale 1ns / 1ps
`default_nettype none

`include "keyframe_linear_interpolator_unit_assert.svh"

module keyframe_linear_interpolator_unit #(
  parameter int unsigned MAX_KEYS = 64
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         cfg_wr_en,
  input  wire logic [6:0]   cfg_wr_data,  // keys_in_use
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // [5:0] key_slot, [37:6] time_ticks, [69:38] value_x, [101:70] value_y,
  // [133:102] value_z, [135:134] zero
  input  wire logic [135:0] in_tdata,
  input  wire logic         in_tuser,     // [0] mode
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic      [95:0]  out_tdata,    // [31:0] out_x, [63:32] out_y, [95:64] out_z
  output logic      [1:0]   out_tuser     // [1:0] status
);

  localparam int unsigned AW = $clog2(MAX_KEYS);
  localparam int unsigned CW = $clog2(MAX_KEYS + 1);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_SCAN  = 4'd1;
  localparam logic [3:0] S_KA    = 4'd2;
  localparam logic [3:0] S_KB    = 4'd3;
  localparam logic [3:0] S_VA    = 4'd4;
  localparam logic [3:0] S_VB    = 4'd5;
  localparam logic [3:0] S_VC    = 4'd6;
  localparam logic [3:0] S_DLOAD = 4'd7;
  localparam logic [3:0] S_DIV   = 4'd8;
  localparam logic [3:0] S_FCAP  = 4'd9;
  localparam logic [3:0] S_MLOAD = 4'd10;
  localparam logic [3:0] S_MUL   = 4'd11;
  localparam logic [3:0] S_FIN   = 4'd12;
  localparam logic [3:0] S_OUT   = 4'd13;

  localparam int unsigned VW = klerp_pkg::VEC_W;

  logic [3:0]  state_r, state_nxt;
  logic [6:0]  keys_r;
  logic [CW-1:0] n_eff;

  logic [AW-1:0] ridx_r, ridx_nxt;
  logic [AW-1:0] cidx_r, cidx_nxt;
  logic [AW-1:0] vaddr_r, vaddr_nxt;
  logic [31:0]   qt_r, qt_nxt;
  logic [31:0]   prev_r, prev_nxt;
  logic [31:0]   off_r, off_nxt;
  logic [31:0]   dt_r, dt_nxt;
  logic [VW-1:0] start_r, start_nxt;
  logic [VW-1:0] end_r, end_nxt;
  logic [31:0]   f_r, f_nxt;
  logic [31:0]   mag_r, mag_nxt;
  logic          neg_r, neg_nxt;
  logic [31:0]   cstart_r, cstart_nxt;
  logic [1:0]    comp_r, comp_nxt;
  logic [4:0]    step_r, step_nxt;
  logic [VW-1:0] res_r, res_nxt;
  klerp_pkg::status_t res_st_r, res_st_nxt;
  logic [VW-1:0] out_data_r, out_data_nxt;
  klerp_pkg::status_t out_st_r, out_st_nxt;
  logic          out_valid_r, out_valid_nxt;

  logic [5:0]    in_slot;
  logic [31:0]   in_time;
  logic [AW+5:0] slot_ext;
  logic          slot_ok;
  logic          key_wr;
  logic [AW-1:0] t_raddr;
  logic [31:0]   t_rdata;
  logic [VW-1:0] v_rdata;

  klerp_pkg::cmd_t cmd;
  logic [31:0] quot;
  logic [31:0] unit_res;

  logic [31:0] cs, ce;
  logic [32:0] d_w, neg_d;

  assign in_slot  = in_tdata[5:0];
  assign in_time  = in_tdata[37:6];
  assign slot_ext = (AW + 6)'(in_slot);
  assign slot_ok  = 32'(in_slot) < 32'(MAX_KEYS);
  assign key_wr   = in_tvalid && in_tready && !in_tuser && slot_ok;
  assign t_raddr  = (state_r == S_IDLE) ? '0 : ridx_r;

  always_comb begin
    if (keys_r == 7'd0) begin
      n_eff = CW'(1);
    end else if (32'(keys_r) > 32'(MAX_KEYS)) begin
      n_eff = CW'(MAX_KEYS);
    end else begin
      n_eff = CW'(keys_r);
    end
  end

  klerp_ram #(.WIDTH(32), .DEPTH(MAX_KEYS)) u_time_ram (
    .clk     (clk),
    .wr_en   (key_wr),
    .wr_addr (slot_ext[AW-1:0]),
    .wr_data (in_time),
    .rd_addr (t_raddr),
    .rd_data (t_rdata)
  );

  klerp_ram #(.WIDTH(VW), .DEPTH(MAX_KEYS)) u_vec_ram (
    .clk     (clk),
    .wr_en   (key_wr),
    .wr_addr (slot_ext[AW-1:0]),
    .wr_data (in_tdata[133:38]),
    .rd_addr (vaddr_r),
    .rd_data (v_rdata)
  );

  klerp_arith u_arith (
    .clk       (clk),
    .cmd       (cmd),
    .div_off   (off_r),
    .div_den   (dt_r),
    .mul_f     (f_r),
    .mul_mag   (mag_r),
    .fin_start (cstart_r),
    .quot      (quot),
    .result    (unit_res)
  );

  // component select for the multiply set-up
  always_comb begin
    case (comp_r)
      2'd0: begin
        cs = start_r[31:0];
        ce = end_r[31:0];
      end
      2'd1: begin
        cs = start_r[63:32];
        ce = end_r[63:32];
      end
      default: begin
        cs = start_r[95:64];
        ce = end_r[95:64];
      end
    endcase
  end

  assign d_w   = {ce[31], ce} - {cs[31], cs};
  assign neg_d = 33'd0 - d_w;

  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    state_nxt     = state_r;
    ridx_nxt      = ridx_r;
    cidx_nxt      = cidx_r;
    vaddr_nxt     = vaddr_r;
    qt_nxt        = qt_r;
    prev_nxt      = prev_r;
    off_nxt       = off_r;
    dt_nxt        = dt_r;
    start_nxt     = start_r;
    end_nxt       = end_r;
    f_nxt         = f_r;
    mag_nxt       = mag_r;
    neg_nxt       = neg_r;
    cstart_nxt    = cstart_r;
    comp_nxt      = comp_r;
    step_nxt      = step_r;
    res_nxt       = res_r;
    res_st_nxt    = res_st_r;
    out_data_nxt  = out_data_r;
    out_st_nxt    = out_st_r;
    out_valid_nxt = out_valid_r;
    cmd.op        = klerp_pkg::OP_NONE;
    cmd.neg       = neg_r;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_tvalid && in_tuser) begin
          qt_nxt   = in_time;
          ridx_nxt = AW'(1);
          cidx_nxt = '0;
          if (n_eff == CW'(1)) begin
            vaddr_nxt  = '0;
            res_st_nxt = klerp_pkg::ST_SINGLE;
            state_nxt  = S_KA;
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        // t_rdata holds the time of key cidx
        ridx_nxt = ridx_r + AW'(1);
        cidx_nxt = cidx_r + AW'(1);
        prev_nxt = t_rdata;
        if (qt_r < t_rdata) begin
          if (cidx_r == '0) begin
            vaddr_nxt  = '0;
            res_st_nxt = klerp_pkg::ST_CLAMP;
            state_nxt  = S_KA;
          end else begin
            vaddr_nxt = cidx_r - AW'(1);
            off_nxt   = qt_r - prev_r;
            dt_nxt    = t_rdata - prev_r;
            state_nxt = S_VA;
          end
        end else if (32'(cidx_r) + 32'd1 == 32'(n_eff)) begin
          vaddr_nxt  = cidx_r;
          res_st_nxt = klerp_pkg::ST_CLAMP;
          state_nxt  = S_KA;
        end
      end
      S_KA: begin
        state_nxt = S_KB;
      end
      S_KB: begin
        res_nxt   = v_rdata;
        state_nxt = S_OUT;
      end
      S_VA: begin
        vaddr_nxt = vaddr_r + AW'(1);
        state_nxt = S_VB;
      end
      S_VB: begin
        start_nxt = v_rdata;
        state_nxt = S_VC;
      end
      S_VC: begin
        end_nxt   = v_rdata;
        state_nxt = S_DLOAD;
      end
      S_DLOAD: begin
        cmd.op    = klerp_pkg::OP_LOAD_DIV;
        step_nxt  = '0;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        cmd.op   = klerp_pkg::OP_DIV_STEP;
        step_nxt = step_r + 5'd1;
        if (step_r == 5'd31) begin
          state_nxt = S_FCAP;
        end
      end
      S_FCAP: begin
        f_nxt     = quot;
        comp_nxt  = '0;
        state_nxt = S_MLOAD;
      end
      S_MLOAD: begin
        cmd.op     = klerp_pkg::OP_LOAD_MUL;
        neg_nxt    = d_w[32];
        mag_nxt    = d_w[32] ? neg_d[31:0] : d_w[31:0];
        cstart_nxt = cs;
        step_nxt   = '0;
        state_nxt  = S_MUL;
      end
      S_MUL: begin
        cmd.op   = klerp_pkg::OP_MUL_STEP;
        step_nxt = step_r + 5'd1;
        if (step_r == 5'd31) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        cmd.op     = klerp_pkg::OP_FINAL;
        res_st_nxt = klerp_pkg::ST_INTERP;
        case (comp_r)
          2'd0:    res_nxt[31:0]  = unit_res;
          2'd1:    res_nxt[63:32] = unit_res;
          default: res_nxt[95:64] = unit_res;
        endcase
        if (comp_r == 2'd2) begin
          state_nxt = S_OUT;
        end else begin
          comp_nxt  = comp_r + 2'd1;
          state_nxt = S_MLOAD;
        end
      end
      S_OUT: begin
        if (!out_valid_r || out_tready) begin
          out_data_nxt  = res_r;
          out_st_nxt    = res_st_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      keys_r      <= 7'd1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        keys_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    ridx_r     <= ridx_nxt;
    cidx_r     <= cidx_nxt;
    vaddr_r    <= vaddr_nxt;
    qt_r       <= qt_nxt;
    prev_r     <= prev_nxt;
    off_r      <= off_nxt;
    dt_r       <= dt_nxt;
    start_r    <= start_nxt;
    end_r      <= end_nxt;
    f_r        <= f_nxt;
    mag_r      <= mag_nxt;
    neg_r      <= neg_nxt;
    cstart_r   <= cstart_nxt;
    comp_r     <= comp_nxt;
    step_r     <= step_nxt;
    res_r      <= res_nxt;
    res_st_r   <= res_st_nxt;
    out_data_r <= out_data_nxt;
    out_st_r   <= out_st_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_st_r;

  `KLI_ASSERT_NXT(a_single_key, state_r == S_IDLE && in_tvalid && in_tuser && n_eff == CW'(1), state_r == S_KA && res_st_r == klerp_pkg::ST_SINGLE, "single key query did not go to key read")
  `KLI_ASSERT_IMP(a_scan_bound, state_r == S_SCAN, 32'(cidx_r) < 32'(n_eff), "search ran past the last key in use")
  `KLI_ASSERT_NXT(a_div_count, state_r == S_DIV && step_r != 5'd31, state_r == S_DIV && step_r == $past(step_r) + 5'd1, "division left early or skipped a step")
  `KLI_ASSERT_IMP(a_comp_range, state_r == S_MLOAD || state_r == S_FIN, comp_r != 2'd3, "component index out of range")
  `KLI_ASSERT_NXT(a_out_load, state_r == S_OUT && (!out_valid_r || out_tready), out_valid_r && state_r == S_IDLE, "result not loaded into output register")

endmodule

`default_nettype wire

[src/klerp_ram.sv]
// generic single write port, single read port ram with registered read
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module klerp_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

[src/klerp_arith.sv]
// shared 34-bit add/subtract unit: bit-serial division, shift-add multiply, final add
// depends on klerp_pkg
`timescale 1ns / 1ps
`default_nettype none

module klerp_arith (
  input  wire logic            clk,
  input  wire klerp_pkg::cmd_t cmd,
  input  wire logic [31:0]     div_off,
  input  wire logic [31:0]     div_den,
  input  wire logic [31:0]     mul_f,
  input  wire logic [31:0]     mul_mag,
  input  wire logic [31:0]     fin_start,
  output logic      [31:0]     quot,
  output logic      [31:0]     result
);

  // hi holds the remainder or the upper product half, lo the quotient or multiplier
  logic [32:0] hi_r, hi_nxt;
  logic [31:0] lo_r, lo_nxt;
  logic [33:0] add_a, add_b, add_y;
  logic        add_sub;

  always_comb begin
    add_a   = '0;
    add_b   = '0;
    add_sub = 1'b0;
    case (cmd.op)
      klerp_pkg::OP_DIV_STEP: begin
        add_a   = {1'b0, hi_r[31:0], 1'b0};
        add_b   = {2'b00, div_den};
        add_sub = 1'b1;
      end
      klerp_pkg::OP_MUL_STEP: begin
        add_a = {1'b0, hi_r};
        add_b = lo_r[0] ? {2'b00, mul_mag} : 34'd0;
      end
      klerp_pkg::OP_FINAL: begin
        add_a   = {2'b00, fin_start};
        add_b   = {2'b00, hi_r[31:0]};
        add_sub = cmd.neg;
      end
      default: begin
        add_a = '0;
      end
    endcase
  end

  assign add_y = add_sub ? (add_a - add_b) : (add_a + add_b);

  always_comb begin
    hi_nxt = hi_r;
    lo_nxt = lo_r;
    case (cmd.op)
      klerp_pkg::OP_LOAD_DIV: begin
        hi_nxt = {1'b0, div_off};
        lo_nxt = '0;
      end
      klerp_pkg::OP_DIV_STEP: begin
        // restoring step: keep the difference when no borrow
        if (!add_y[33]) begin
          hi_nxt = add_y[32:0];
        end else begin
          hi_nxt = {hi_r[31:0], 1'b0};
        end
        lo_nxt = {lo_r[30:0], ~add_y[33]};
      end
      klerp_pkg::OP_LOAD_MUL: begin
        hi_nxt = '0;
        lo_nxt = mul_f;
      end
      klerp_pkg::OP_MUL_STEP: begin
        hi_nxt = {1'b0, add_y[32:1]};
        lo_nxt = {add_y[0], lo_r[31:1]};
      end
      default: begin
        hi_nxt = hi_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    hi_r <= hi_nxt;
    lo_r <= lo_nxt;
  end

  assign quot   = lo_r;
  assign result = add_y[31:0];

endmodule

`default_nettype wire
